// File: rtl/gaps_pkg.sv
// Shared codes and field widths for the grid path search unit.
package gaps_pkg;

  // Field widths of the item and result channels
  localparam int W_OP     = 2;
  localparam int W_COORD  = 5;
  localparam int W_INDEX  = 10;
  localparam int W_STATUS = 2;
  localparam int W_LENGTH = 11;
  localparam int W_CFG    = 6;
  localparam int W_ENTRY  = 2 * W_COORD;

  // Operation codes
  localparam logic [W_OP-1:0] OP_LOAD   = 2'd0;
  localparam logic [W_OP-1:0] OP_SEARCH = 2'd1;
  localparam logic [W_OP-1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [W_STATUS-1:0] STAT_FOUND  = 2'd0;
  localparam logic [W_STATUS-1:0] STAT_NOPATH = 2'd1;
  localparam logic [W_STATUS-1:0] STAT_LOADED = 2'd2;
  localparam logic [W_STATUS-1:0] STAT_RANGE  = 2'd3;

  // Cell marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_SHUT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Absolute difference of two 7-bit coordinates
  function automatic logic [6:0] abs_diff(input logic [6:0] a, input logic [6:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/grid_astar_path_search_unit.sv
// Grid A* path search unit: wall map load, search and path readback.
//
// One item is worked at a time and each item gives one result. After reset
// the unit clears the whole cell memory of 2^(ceil(log2 MAX_ROWS) +
// ceil(log2 MAX_COLS)) cells (1024 at the defaults), one cell a cycle, and
// holds the item channel stalled until that pass is done. A search first
// sweeps the cell memory once to clear the marks (one cell a cycle) and
// then repeats: a full scan of the cell memory for the open cell with the
// least f (again one cell a cycle) and a pick, then up to four neighbor
// read-modify-writes. When the goal is reached, the path is walked back from
// the goal and written to the path memory; a start equal to the goal or out
// of range finishes without a sweep. The cell memory has a single read and a
// single write port.
module grid_astar_path_search_unit
  import gaps_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [W_OP-1:0]     in_operation,
  input  logic [W_COORD-1:0]  in_cell_row,
  input  logic [W_COORD-1:0]  in_cell_col,
  input  logic                in_is_wall,
  input  logic [W_COORD-1:0]  in_goal_row,
  input  logic [W_COORD-1:0]  in_goal_col,
  input  logic [W_INDEX-1:0]  in_path_index,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [W_STATUS-1:0] out_status,
  output logic [W_LENGTH-1:0] out_path_length,
  output logic [W_COORD-1:0]  out_path_row,
  output logic [W_COORD-1:0]  out_path_col,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [W_CFG-1:0]    cfg_data
);

  localparam int RB     = $clog2(MAX_ROWS);
  localparam int CB     = $clog2(MAX_COLS);
  localparam int AW     = RB + CB;
  localparam int CDEPTH = 1 << AW;
  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int PAW    = $clog2(NCELLS);
  localparam int LW     = $clog2(NCELLS + 1);
  localparam int SW     = $clog2(4 * NCELLS + 2);
  localparam int FW     = LW + 8;

  typedef struct packed {
    logic          wall;
    logic [1:0]    mark;
    logic [LW-1:0] cost;
    logic [1:0]    par;
    logic [SW-1:0] stamp;
  } cell_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CLR_TAIL, S_SCAN, S_SCAN_TAIL, S_PICK,
    S_NB_SEL, S_NB_EVAL, S_RC_WR, S_RC_RD, S_RD_WAIT, S_FIN, S_INIT
  } state_t;

  state_t              state_r;
  logic [W_CFG-1:0]    grid_rows_r, grid_cols_r;
  logic [AW-1:0]       cnt_r;
  logic                rd_pend_r;
  logic [AW-1:0]       rd_addr_q_r;
  logic [AW-1:0]       start_addr_r;
  logic [W_COORD-1:0]  goal_row_r, goal_col_r;
  logic                any_r;
  logic [AW-1:0]       best_addr_r;
  logic [FW-1:0]       best_f_r;
  cell_t               best_word_r;
  logic [SW-1:0]       stamp_r;
  logic [1:0]          nb_dir_r;
  logic [AW-1:0]       nb_addr_r;
  logic [AW-1:0]       cur_r;
  logic [1:0]          par_r;
  logic [LW-1:0]       k_r, len_r;
  logic [LW-1:0]       stored_len_r;
  logic [W_STATUS-1:0] res_status_r;
  logic [W_COORD-1:0]  res_row_r, res_col_r;
  logic                out_valid_r;
  logic [W_STATUS-1:0] out_status_r;
  logic [W_LENGTH-1:0] out_len_r;
  logic [W_COORD-1:0]  out_row_r, out_col_r;

  // Memories
  cell_t               cell_mem [CDEPTH];
  cell_t               rd_word_r;
  logic [W_ENTRY-1:0]  path_mem [NCELLS];
  logic [W_ENTRY-1:0]  path_rd_r;

  logic                cm_we;
  logic [AW-1:0]       cm_wa, cm_ra;
  cell_t               cm_wd;
  logic                pm_we;
  logic [PAW-1:0]      pm_wa, pm_ra;
  logic [W_ENTRY-1:0]  pm_wd;

  logic                accept;
  logic [6:0]          rows_use, cols_use;
  logic                start_same, start_out, load_in, read_ok;
  logic [RB-1:0]       sr, br, cr;
  logic [CB-1:0]       sc, bc, cc;
  logic [6:0]          h_row, h_col;
  logic [FW-1:0]       cand_f;
  logic                better;
  logic                is_goal;
  logic [7:0]          nr8, nc8;
  logic                nb_ok;
  logic [AW-1:0]       nb_addr;
  logic [LW-1:0]       ng;
  logic                nb_skip, nb_take;
  logic [AW-1:0]       rc_next;
  logic                out_free;
  cell_t               start_word, clr_word, nb_word, shut_word;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Grid size in use, saturated to the build limits
  assign rows_use = (7'(grid_rows_r) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(grid_rows_r);
  assign cols_use = (7'(grid_cols_r) > 7'(MAX_COLS)) ? 7'(MAX_COLS) : 7'(grid_cols_r);

  // Item decode
  assign start_same = (in_cell_row == in_goal_row) && (in_cell_col == in_goal_col);
  assign start_out  = (32'(in_cell_row) >= MAX_ROWS) || (32'(in_cell_col) >= MAX_COLS);
  assign load_in    = (32'(in_cell_row) < MAX_ROWS) && (32'(in_cell_col) < MAX_COLS);
  assign read_ok    = (16'(in_path_index) < 16'(stored_len_r)) &&
                      (32'(in_path_index) < NCELLS);
  assign sr = RB'(in_cell_row);
  assign sc = CB'(in_cell_col);

  // Scan: f of the cell whose data just arrived
  assign h_row  = abs_diff(7'(rd_addr_q_r[AW-1:CB]), 7'(goal_row_r));
  assign h_col  = abs_diff(7'(rd_addr_q_r[CB-1:0]), 7'(goal_col_r));
  assign cand_f = (rd_addr_q_r == start_addr_r) ? '0 :
                  FW'(rd_word_r.cost) + FW'(h_row) + FW'(h_col);
  assign better = (state_r == S_SCAN || state_r == S_SCAN_TAIL) && rd_pend_r &&
                  (rd_word_r.mark == MARK_OPEN) &&
                  (!any_r || (cand_f < best_f_r) ||
                   ((cand_f == best_f_r) && (rd_word_r.stamp > best_word_r.stamp)));

  assign br = best_addr_r[AW-1:CB];
  assign bc = best_addr_r[CB-1:0];
  assign is_goal = (7'(br) == 7'(goal_row_r)) && (7'(bc) == 7'(goal_col_r));

  // Neighbor of the expanded cell in direction nb_dir_r
  always_comb begin
    nr8 = 8'(br);
    nc8 = 8'(bc);
    unique case (nb_dir_r)
      2'd0: nr8 = 8'(br) - 8'd1;
      2'd1: nc8 = 8'(bc) - 8'd1;
      2'd2: nc8 = 8'(bc) + 8'd1;
      2'd3: nr8 = 8'(br) + 8'd1;
      default: nr8 = 8'(br);
    endcase
  end
  assign nb_ok = !((nb_dir_r == 2'd0) && (br == '0)) &&
                 !((nb_dir_r == 2'd1) && (bc == '0)) &&
                 (nr8 < 8'(rows_use)) && (nc8 < 8'(cols_use));
  assign nb_addr = {RB'(nr8), CB'(nc8)};
  assign ng      = best_word_r.cost + LW'(1);
  assign nb_skip = (rd_word_r.mark == MARK_SHUT) || rd_word_r.wall;
  assign nb_take = (rd_word_r.mark != MARK_OPEN) || (ng < rd_word_r.cost);

  // Path walk: step from cur_r toward its parent
  assign cr = cur_r[AW-1:CB];
  assign cc = cur_r[CB-1:0];
  always_comb begin
    unique case (par_r)
      2'd0: rc_next = {cr - RB'(1), cc};
      2'd1: rc_next = {cr, cc - CB'(1)};
      2'd2: rc_next = {cr, cc + CB'(1)};
      2'd3: rc_next = {cr + RB'(1), cc};
      default: rc_next = cur_r;
    endcase
  end

  // Cell words written back
  always_comb begin
    start_word       = '0;
    start_word.wall  = rd_word_r.wall;
    start_word.mark  = MARK_OPEN;
    start_word.stamp = SW'(1);
    clr_word         = rd_word_r;
    clr_word.mark    = MARK_FREE;
    shut_word        = best_word_r;
    shut_word.mark   = MARK_SHUT;
    nb_word          = rd_word_r;
    nb_word.stamp    = stamp_r + SW'(1);
    if (nb_take) begin
      nb_word.mark = MARK_OPEN;
      nb_word.cost = ng;
      nb_word.par  = 2'd3 - nb_dir_r;
    end
  end

  // Cell memory port control
  always_comb begin
    cm_we = 1'b0;
    cm_wa = rd_addr_q_r;
    cm_wd = clr_word;
    cm_ra = cnt_r;
    unique case (state_r)
      S_INIT: begin
        cm_we = 1'b1;
        cm_wa = cnt_r;
        cm_wd = '0;
      end
      S_IDLE: begin
        if (accept && in_operation == OP_LOAD && load_in) begin
          cm_we      = 1'b1;
          cm_wa      = {sr, sc};
          cm_wd      = '0;
          cm_wd.wall = in_is_wall;
        end
      end
      S_CLR, S_CLR_TAIL: begin
        cm_we = rd_pend_r;
        cm_wd = (rd_addr_q_r == start_addr_r) ? start_word : clr_word;
      end
      S_PICK: begin
        cm_we = any_r && !is_goal;
        cm_wa = best_addr_r;
        cm_wd = shut_word;
      end
      S_NB_SEL: cm_ra = nb_addr;
      S_NB_EVAL: begin
        cm_we = !nb_skip;
        cm_wa = nb_addr_r;
        cm_wd = nb_word;
      end
      S_RC_WR: cm_ra = rc_next;
      default: cm_ra = cnt_r;
    endcase
  end

  // Path memory port control
  always_comb begin
    pm_we = 1'b0;
    pm_wa = PAW'(k_r - LW'(1));
    pm_wd = {5'(cr), 5'(cc)};
    pm_ra = PAW'(in_path_index);
    if (state_r == S_IDLE && accept && in_operation == OP_SEARCH && start_same) begin
      pm_we = 1'b1;
      pm_wa = '0;
      pm_wd = {in_cell_row, in_cell_col};
    end else if (state_r == S_RC_WR) begin
      pm_we = 1'b1;
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_wa] <= cm_wd;
    rd_word_r <= cell_mem[cm_ra];
  end

  // Path memory
  always_ff @(posedge clk) begin
    if (pm_we) path_mem[pm_wa] <= pm_wd;
    path_rd_r <= path_mem[pm_ra];
  end

  // Sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      grid_rows_r  <= W_CFG'(32);
      grid_cols_r  <= W_CFG'(32);
      stored_len_r <= '0;
      stamp_r      <= '0;
      rd_pend_r    <= 1'b0;
      any_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r   <= (state_r == S_CLR) || (state_r == S_SCAN);
      rd_addr_q_r <= cnt_r;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: grid_rows_r <= cfg_data;
          CFG_COLS: grid_cols_r <= cfg_data;
          default:  grid_rows_r <= grid_rows_r;
        endcase
      end

      // Result valid: set on a finished item, dropped on a transfer
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (better) begin
        any_r       <= 1'b1;
        best_addr_r <= rd_addr_q_r;
        best_f_r    <= cand_f;
        best_word_r <= rd_word_r;
      end

      unique case (state_r)
        // Cell memory clearing pass after reset
        S_INIT: begin
          cnt_r <= cnt_r + AW'(1);
          if (&cnt_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            res_row_r <= '0;
            res_col_r <= '0;
            priority if (in_operation == OP_LOAD) begin
              res_status_r <= STAT_LOADED;
              state_r      <= S_FIN;
            end else if (in_operation == OP_SEARCH) begin
              if (start_same) begin
                stamp_r      <= '0;
                stored_len_r <= LW'(1);
                res_status_r <= STAT_FOUND;
                state_r      <= S_FIN;
              end else if (start_out) begin
                stamp_r      <= '0;
                stored_len_r <= '0;
                res_status_r <= STAT_NOPATH;
                state_r      <= S_FIN;
              end else begin
                stored_len_r <= '0;
                start_addr_r <= {sr, sc};
                goal_row_r   <= in_goal_row;
                goal_col_r   <= in_goal_col;
                stamp_r      <= SW'(1);
                cnt_r        <= '0;
                state_r      <= S_CLR;
              end
            end else if (in_operation == OP_READ && read_ok) begin
              res_status_r <= STAT_FOUND;
              state_r      <= S_RD_WAIT;
            end else begin
              res_status_r <= STAT_RANGE;
              state_r      <= S_FIN;
            end
          end
        end
        // Clearing sweep; the start cell is opened on the way
        S_CLR: begin
          cnt_r <= cnt_r + AW'(1);
          if (&cnt_r) state_r <= S_CLR_TAIL;
        end
        S_CLR_TAIL: begin
          any_r   <= 1'b0;
          state_r <= S_SCAN;
        end
        // Open-set scan for the least f
        S_SCAN: begin
          cnt_r <= cnt_r + AW'(1);
          if (&cnt_r) state_r <= S_SCAN_TAIL;
        end
        S_SCAN_TAIL: state_r <= S_PICK;
        S_PICK: begin
          priority if (!any_r) begin
            res_status_r <= STAT_NOPATH;
            state_r      <= S_FIN;
          end else if (is_goal) begin
            k_r     <= best_word_r.cost + LW'(1);
            len_r   <= best_word_r.cost + LW'(1);
            cur_r   <= best_addr_r;
            par_r   <= best_word_r.par;
            state_r <= S_RC_WR;
          end else begin
            nb_dir_r <= 2'd0;
            state_r  <= S_NB_SEL;
          end
        end
        // Neighbor relaxation, one direction at a time
        S_NB_SEL: begin
          if (nb_ok) begin
            nb_addr_r <= nb_addr;
            state_r   <= S_NB_EVAL;
          end else if (nb_dir_r == 2'd3) begin
            cnt_r   <= '0;
            any_r   <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            nb_dir_r <= nb_dir_r + 2'd1;
          end
        end
        S_NB_EVAL: begin
          if (!nb_skip) stamp_r <= stamp_r + SW'(1);
          if (nb_dir_r == 2'd3) begin
            cnt_r   <= '0;
            any_r   <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            nb_dir_r <= nb_dir_r + 2'd1;
            state_r  <= S_NB_SEL;
          end
        end
        // Path walk from goal back to start
        S_RC_WR: begin
          if (k_r == LW'(1)) begin
            stored_len_r <= len_r;
            res_status_r <= STAT_FOUND;
            state_r      <= S_FIN;
          end else begin
            k_r     <= k_r - LW'(1);
            cur_r   <= rc_next;
            state_r <= S_RC_RD;
          end
        end
        S_RC_RD: begin
          par_r   <= rd_word_r.par;
          state_r <= S_RC_WR;
        end
        S_RD_WAIT: begin
          res_row_r <= path_rd_r[W_ENTRY-1:W_COORD];
          res_col_r <= path_rd_r[W_COORD-1:0];
          state_r   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_len_r    <= W_LENGTH'(stored_len_r);
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_path_length = out_len_r;
  assign out_path_row    = out_row_r;
  assign out_path_col    = out_col_r;

  // An accepted item always leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item transfer did not leave idle");

  // No stored path while a search is scanning
  a_len_clear_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (stored_len_r == '0))
    else $error("path length not cleared during search");

  // The path walk never runs past the start entry
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RC_WR) |-> (k_r != '0))
    else $error("path walk count reached zero");

endmodule
